// ===== rtl/core/nsc_pkg.sv =====
// Package for the numeric string classifier: character codes, length limits,
// the per-string scan state type and the verdict type.
// No dependencies.
package nsc_pkg;

  // Character codes that the scan recognizes.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Length and dot counters saturate at these values.
  localparam logic [2:0] LEN_SAT = 3'd4;
  localparam logic [1:0] DOT_SAT = 2'd2;

  // Length limits used by the verdict.
  localparam logic [2:0] NEG_ZERO_CHECK_LEN = 3'd3;  // zero check once length exceeds this
  localparam logic [2:0] NEG_FRAC_MIN_LEN   = 3'd4;
  localparam logic [2:0] POS_FRAC_MIN_LEN   = 3'd3;

  // Position codes within the string.
  localparam logic [2:0] POS_FIRST  = 3'd0;
  localparam logic [2:0] POS_SECOND = 3'd1;
  localparam logic [2:0] POS_THIRD  = 3'd2;

  // Flags gathered while a string streams in.
  typedef struct packed {
    logic [2:0] char_count;
    logic       minus_lead;
    logic       first_is_zero;
    logic       second_is_zero;
    logic [1:0] dot_count;
    logic       bad_seen;
    logic       dot_at_first;
    logic       dot_at_second;
    logic       dot_at_third;
  } scan_state_t;

  localparam scan_state_t SCAN_CLEAR = '0;

  typedef enum logic [1:0] {
    VERDICT_NAN  = 2'd0,
    VERDICT_INT  = 2'd1,
    VERDICT_FRAC = 2'd2
  } verdict_kind_t;

  typedef struct packed {
    verdict_kind_t kind;
    logic          neg;
  } verdict_t;

endpackage

// ===== rtl/core/nsc_char_step.sv =====
// Folds one character into the scan state of the current string.
// Depends on nsc_pkg.
module nsc_char_step (
  input  nsc_pkg::scan_state_t state_i,
  input  logic [7:0]           char_i,
  output nsc_pkg::scan_state_t state_o
);

  logic [2:0] pos;
  logic       is_dot;
  logic       is_digit;
  logic       is_minus;
  logic       is_zero;

  assign pos      = state_i.char_count;
  assign is_dot   = (char_i == nsc_pkg::CHAR_DOT);
  assign is_minus = (char_i == nsc_pkg::CHAR_MINUS);
  assign is_zero  = (char_i == nsc_pkg::CHAR_ZERO);
  assign is_digit = (char_i inside {[nsc_pkg::CHAR_ZERO:nsc_pkg::CHAR_NINE]});

  always_comb begin
    state_o = state_i;

    // Position-dependent flags.
    case (pos)
      nsc_pkg::POS_FIRST: begin
        state_o.minus_lead    = is_minus;
        state_o.first_is_zero = is_zero;
        state_o.dot_at_first  = is_dot;
      end
      nsc_pkg::POS_SECOND: begin
        state_o.second_is_zero = is_zero;
        state_o.dot_at_second  = is_dot;
      end
      nsc_pkg::POS_THIRD: begin
        state_o.dot_at_third = is_dot;
      end
      default: begin
      end
    endcase

    // A leading minus is the only non-digit, non-dot character allowed.
    if (!(pos == nsc_pkg::POS_FIRST && is_minus)) begin
      if (is_dot) begin
        if (state_i.dot_count < nsc_pkg::DOT_SAT) begin
          state_o.dot_count = state_i.dot_count + 2'd1;
        end
      end else if (!is_digit) begin
        state_o.bad_seen = 1'b1;
      end
    end

    // Length saturates.
    if (state_i.char_count < nsc_pkg::LEN_SAT) begin
      state_o.char_count = state_i.char_count + 3'd1;
    end
  end

endmodule

// ===== rtl/core/nsc_verdict.sv =====
// Judges a complete string from its scan state and its final character.
// Depends on nsc_pkg.
module nsc_verdict (
  input  nsc_pkg::scan_state_t st_i,
  input  logic                 last_dot_i,
  output nsc_pkg::verdict_t    verdict_o
);

  logic [2:0] len;

  assign len = st_i.char_count;

  always_comb begin
    verdict_o.kind = nsc_pkg::VERDICT_NAN;
    verdict_o.neg  = 1'b0;
    if (len == 3'd0 || st_i.bad_seen) begin
      verdict_o.kind = nsc_pkg::VERDICT_NAN;
    end else if (st_i.dot_count == 2'd0) begin
      // Integer: the leading-zero rule depends on the sign.
      if (st_i.minus_lead ? (len > nsc_pkg::NEG_ZERO_CHECK_LEN && st_i.second_is_zero)
                          : st_i.first_is_zero) begin
        verdict_o.kind = nsc_pkg::VERDICT_NAN;
      end else begin
        verdict_o.kind = nsc_pkg::VERDICT_INT;
        verdict_o.neg  = st_i.minus_lead;
      end
    end else if (st_i.dot_count == 2'd1) begin
      // Fraction: length, leading-zero and dot placement rules.
      if (st_i.minus_lead) begin
        if (!(len < nsc_pkg::NEG_FRAC_MIN_LEN) &&
            !(st_i.second_is_zero && !st_i.dot_at_third) &&
            !(last_dot_i || st_i.dot_at_second)) begin
          verdict_o.kind = nsc_pkg::VERDICT_FRAC;
          verdict_o.neg  = 1'b1;
        end
      end else begin
        if (!(len < nsc_pkg::POS_FRAC_MIN_LEN) &&
            !(st_i.first_is_zero && !st_i.dot_at_second) &&
            !(last_dot_i || st_i.dot_at_first)) begin
          verdict_o.kind = nsc_pkg::VERDICT_FRAC;
        end
      end
    end
  end

endmodule

// ===== rtl/core/numeric_string_classifier_unit.sv =====
// Top level of the numeric string classifier: input register, scan state,
// verdict logic and output register. Depends on nsc_pkg, nsc_char_step, nsc_verdict.
//
//   channel | ports                                      | beat
//   in      | in_valid/in_ready, in_char_code,           | one character
//           | in_no_char, in_last_char                   |
//   out     | out_valid/out_ready, out_is_number,        | one verdict per string
//           | out_has_fraction, out_is_negative          |
//
// One character is taken every cycle unless a waiting verdict stalls a last beat;
// the verdict of a string is registered in the output register when its last beat moves on.
// The input register feeds the state update and the verdict logic directly;
// the output register decouples the result side.
// A waiting verdict stalls only a following last beat; other beats keep flowing.
// Synchronous active-low reset clears the scan state and both valid flags.
module numeric_string_classifier_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_no_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_number,
  output logic       out_has_fraction,
  output logic       out_is_negative
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] char_r;
  logic       no_char_r;
  logic       last_r;

  // Scan state and output register.
  nsc_pkg::scan_state_t state_r, state_nxt;
  nsc_pkg::scan_state_t stepped;
  nsc_pkg::verdict_t    verdict;
  logic out_valid_r;
  logic is_number_r, has_fraction_r, is_negative_r;

  logic slot_free;
  logic proc;

  // The buffered beat moves on unless it needs an occupied output slot.
  assign slot_free = !out_valid_r || out_ready;
  assign proc      = in_valid_r && (!last_r || slot_free);
  assign in_ready  = !in_valid_r || proc;

  nsc_char_step u_step (
    .state_i (state_r),
    .char_i  (char_r),
    .state_o (stepped)
  );

  nsc_verdict u_verdict (
    .st_i       (stepped),
    .last_dot_i (char_r == nsc_pkg::CHAR_DOT),
    .verdict_o  (verdict)
  );

  // Next scan state: cleared after every verdict, unchanged on empty beats.
  always_comb begin
    state_nxt = state_r;
    if (proc) begin
      if (last_r) begin
        state_nxt = nsc_pkg::SCAN_CLEAR;
      end else if (!no_char_r) begin
        state_nxt = stepped;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      char_r    <= in_char_code;
      no_char_r <= in_no_char;
      last_r    <= in_last_char;
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nsc_pkg::SCAN_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register; an empty final beat always gives not a number.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (proc && last_r) begin
      is_number_r    <= !no_char_r && (verdict.kind != nsc_pkg::VERDICT_NAN);
      has_fraction_r <= !no_char_r && (verdict.kind == nsc_pkg::VERDICT_FRAC);
      is_negative_r  <= !no_char_r && (verdict.kind != nsc_pkg::VERDICT_NAN) && verdict.neg;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_number    = is_number_r;
  assign out_has_fraction = has_fraction_r;
  assign out_is_negative  = is_negative_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for numeric_string_classifier_unit: random and directed strings,
// a predictor of the verdict for each string, and a checker on the result channel.
// Depends on nsc_pkg and the numeric_string_classifier_unit RTL.
module tb;

  localparam int ITEM_TARGET   = 1150;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  // One input beat: a character, or an empty marker, with the end-of-string flag.
  typedef struct packed {
    logic [7:0] code;
    logic       none;
    logic       last;
  } char_beat_t;

  // One verdict as it appears on the result channel.
  typedef struct packed {
    logic is_number;
    logic has_fraction;
    logic is_negative;
  } string_verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'd0;
  logic       in_no_char = 1'b0;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_number;
  logic       out_has_fraction;
  logic       out_is_negative;

  char_beat_t           pending_q[$];
  string_verdict_t      verdict_q[$];
  nsc_pkg::scan_state_t scan_flags = nsc_pkg::SCAN_CLEAR;
  int                   total_beats = 0;
  int                   beats_in = 0;
  int                   mismatch_count = 0;
  int                   hold_left = 0;
  bit                   hold_done = 1'b0;
  int                   stall_cycles = 0;

  numeric_string_classifier_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_no_char       (in_no_char),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_number    (out_is_number),
    .out_has_fraction (out_has_fraction),
    .out_is_negative  (out_is_negative)
  );

  always #4 clk = ~clk;

  // Fold one character into the scan flags of the current string.
  function automatic nsc_pkg::scan_state_t absorb_char(nsc_pkg::scan_state_t s,
                                                       logic [7:0] c);
    logic is_dot;
    logic is_digit;
    is_dot   = (c == nsc_pkg::CHAR_DOT);
    is_digit = (c >= nsc_pkg::CHAR_ZERO) && (c <= nsc_pkg::CHAR_NINE);
    case (s.char_count)
      nsc_pkg::POS_FIRST: begin
        s.minus_lead    = (c == nsc_pkg::CHAR_MINUS);
        s.first_is_zero = (c == nsc_pkg::CHAR_ZERO);
        s.dot_at_first  = is_dot;
      end
      nsc_pkg::POS_SECOND: begin
        s.second_is_zero = (c == nsc_pkg::CHAR_ZERO);
        s.dot_at_second  = is_dot;
      end
      nsc_pkg::POS_THIRD: begin
        s.dot_at_third = is_dot;
      end
      default: ;
    endcase
    // A minus sign is legal only in the first position.
    if (!(s.char_count == nsc_pkg::POS_FIRST && c == nsc_pkg::CHAR_MINUS)) begin
      if (is_dot) begin
        if (s.dot_count < nsc_pkg::DOT_SAT) s.dot_count = s.dot_count + 2'd1;
      end else if (!is_digit) begin
        s.bad_seen = 1'b1;
      end
    end
    if (s.char_count < nsc_pkg::LEN_SAT) s.char_count = s.char_count + 3'd1;
    return s;
  endfunction

  // Decide the verdict of a complete string from its scan flags.
  function automatic nsc_pkg::verdict_t classify_string(nsc_pkg::scan_state_t s,
                                                        logic last_dot);
    nsc_pkg::verdict_t v;
    logic              lead_zero;
    v.kind = nsc_pkg::VERDICT_NAN;
    v.neg  = 1'b0;
    if (s.char_count == 3'd0 || s.bad_seen) return v;
    if (s.dot_count == 2'd0) begin
      // Negative strings only check for a leading zero once they are long enough.
      lead_zero = s.minus_lead ?
                  (s.char_count > nsc_pkg::NEG_ZERO_CHECK_LEN && s.second_is_zero) :
                  s.first_is_zero;
      if (!lead_zero) begin
        v.kind = nsc_pkg::VERDICT_INT;
        v.neg  = s.minus_lead;
      end
    end else if (s.dot_count == 2'd1) begin
      if (s.minus_lead) begin
        if (s.char_count >= nsc_pkg::NEG_FRAC_MIN_LEN &&
            !(s.second_is_zero && !s.dot_at_third) &&
            !(last_dot || s.dot_at_second)) begin
          v.kind = nsc_pkg::VERDICT_FRAC;
          v.neg  = 1'b1;
        end
      end else if (s.char_count >= nsc_pkg::POS_FRAC_MIN_LEN &&
                   !(s.first_is_zero && !s.dot_at_second) &&
                   !(last_dot || s.dot_at_first)) begin
        v.kind = nsc_pkg::VERDICT_FRAC;
      end
    end
    return v;
  endfunction

  function automatic int sender_idle_pct();
    if (beats_in < total_beats / 3) return 15;
    if (beats_in < 2 * total_beats / 3) return 65;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (beats_in < total_beats / 3) return 65;
    if (beats_in < 2 * total_beats / 3) return 15;
    return 0;
  endfunction

  task automatic push_beat(logic [7:0] code, logic none, logic last);
    char_beat_t b;
    b.code = code;
    b.none = none;
    b.last = last;
    pending_q.insert(pending_q.size(), b);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_beat(s[i], 1'b0, i == s.len() - 1);
  endtask

  // Mostly well-formed strings with random digits, a sign and a dot, plus some noise.
  task automatic add_random_string();
    int         len;
    int         dot_at;
    bit         neg;
    logic [7:0] c;
    if ($urandom_range(24) == 0) begin
      push_beat(8'($urandom_range(255)), 1'b1, 1'b1);
      return;
    end
    len    = ($urandom_range(9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 5);
    neg    = ($urandom_range(9) < 4);
    dot_at = ($urandom_range(1) == 1) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (neg && i == 0) c = nsc_pkg::CHAR_MINUS;
      else if (i == dot_at) c = nsc_pkg::CHAR_DOT;
      else if ($urandom_range(3) == 0) c = nsc_pkg::CHAR_ZERO;
      else c = nsc_pkg::CHAR_ZERO + 8'($urandom_range(9));
      case ($urandom_range(39))
        0: c = 8'($urandom_range(255));
        1: c = nsc_pkg::CHAR_MINUS;
        2: c = nsc_pkg::CHAR_DOT;
        default: ;
      endcase
      if ($urandom_range(29) == 0) push_beat(8'($urandom_range(255)), 1'b1, 1'b0);
      if (i == len - 1 && $urandom_range(24) == 0) begin
        // The string ends on an empty beat, which discards what came before.
        push_beat(c, 1'b0, 1'b0);
        push_beat(8'($urandom_range(255)), 1'b1, 1'b1);
      end else begin
        push_beat(c, 1'b0, i == len - 1);
      end
    end
  endtask

  task automatic flag_error(string msg);
    if (mismatch_count < REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Driver: offers queued beats and predicts the verdict as each beat is accepted.
  always @(posedge clk) begin
    nsc_pkg::verdict_t v;
    string_verdict_t   want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        beats_in++;
        if (in_last_char) begin
          v.kind = nsc_pkg::VERDICT_NAN;
          v.neg  = 1'b0;
          if (!in_no_char) begin
            scan_flags = absorb_char(scan_flags, in_char_code);
            v = classify_string(scan_flags, in_char_code == nsc_pkg::CHAR_DOT);
          end
          want.is_number    = (v.kind != nsc_pkg::VERDICT_NAN);
          want.has_fraction = (v.kind == nsc_pkg::VERDICT_FRAC);
          want.is_negative  = (v.kind != nsc_pkg::VERDICT_NAN) && v.neg;
          verdict_q.insert(verdict_q.size(), want);
          scan_flags = nsc_pkg::SCAN_CLEAR;
        end else if (!in_no_char) begin
          scan_flags = absorb_char(scan_flags, in_char_code);
        end
      end
      // Load the next beat only when the current one is gone.
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          char_beat_t b;
          b = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_char_code <= b.code;
          in_no_char   <= b.none;
          in_last_char <= b.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each verdict beat and applies back-pressure.
  always @(posedge clk) begin
    string_verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected verdict num=%0b frac=%0b neg=%0b",
                               out_is_number, out_has_fraction, out_is_negative));
        end else begin
          want = verdict_q.pop_front();
          if (out_is_number !== want.is_number || out_has_fraction !== want.has_fraction ||
              out_is_negative !== want.is_negative)
            flag_error($sformatf("verdict num/frac/neg expected %0b/%0b/%0b got %0b/%0b/%0b",
                                 want.is_number, want.has_fraction, want.is_negative,
                                 out_is_number, out_has_fraction, out_is_negative));
        end
      end
      // One long hold-off while the sender keeps going, so the input side backs up.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && beats_in >= 2 * total_beats / 3 + 40) begin
        hold_done = 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed strings: sign, zero and dot quirks, bad characters, empty beats.
    push_beat(8'h00, 1'b1, 1'b1);
    push_text("0");
    push_text("-");
    push_text("9");
    push_text("-0");
    push_text("0.5");
    push_text("-0.5");
    push_text("12.");
    push_beat(8'hFF, 1'b0, 1'b1);
    push_text("-1-");
    push_beat("5", 1'b0, 1'b0);
    push_beat(8'hA5, 1'b1, 1'b0);
    push_beat("0", 1'b0, 1'b1);
    push_beat("7", 1'b0, 1'b0);
    push_beat(8'h5A, 1'b1, 1'b1);
    push_beat(8'h00, 1'b0, 1'b1);
    push_text("1..");
    while (pending_q.size() < ITEM_TARGET) add_random_string();
    total_beats = pending_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (verdict_q.size() != 0) flag_error($sformatf("%0d verdicts never arrived",
                                                    verdict_q.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
